// File: rtl/msc_pkg.sv
// Shared codes and types of the MSI snoop controller: line states, bus
// commands, beat kinds and the result record.
// No dependencies.
`default_nettype none

package msc_pkg;

   // Line state codes
   localparam logic [2:0] ST_I  = 3'd0;
   localparam logic [2:0] ST_S  = 3'd1;
   localparam logic [2:0] ST_M  = 3'd2;
   localparam logic [2:0] ST_SM = 3'd3;
   localparam logic [2:0] ST_IM = 3'd4;

   // Bus command codes
   localparam logic [1:0] CMD_INV = 2'd0;
   localparam logic [1:0] CMD_RD  = 2'd1;
   localparam logic [1:0] CMD_RDX = 2'd2;

   // Request beat kinds
   localparam logic [2:0] KIND_INV       = 3'd0;
   localparam logic [2:0] KIND_RD        = 3'd1;
   localparam logic [2:0] KIND_RDX       = 3'd2;
   localparam logic [2:0] KIND_REQUEST   = 3'd3;
   localparam logic [2:0] KIND_STATE_SET = 3'd4;

   localparam int ADDR_BITS     = 32;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 48;

   // One result record
   typedef struct packed {
      logic [2:0]           line_state_after;
      logic                 lost_upgrade;
      logic                 ignored;
      logic                 fill_valid;
      logic [ADDR_BITS-1:0] writeback_address;
      logic                 writeback_valid;
      logic [1:0]           command;
      logic                 command_valid;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/msc_line_store.sv
// Line tag/state memory of the snoop controller: one synchronous array with
// registered read, write bypass and a clearing sweep after reset.
// Depends on nothing but its parameters.
`default_nettype none

module msc_line_store #(
   parameter int INDEX_BITS = 6,
   parameter int DATA_BITS  = 25
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   output logic                       ready,
   input  wire logic                  rd_en,
   input  wire logic [INDEX_BITS-1:0] rd_idx,
   output logic [DATA_BITS-1:0]       rd_data,
   input  wire logic                  wr_en,
   input  wire logic [INDEX_BITS-1:0] wr_idx,
   input  wire logic [DATA_BITS-1:0]  wr_data
);

   localparam int LINES = 1 << INDEX_BITS;

   logic [DATA_BITS-1:0]  mem [LINES];
   logic [DATA_BITS-1:0]  rd_data_ff;
   logic                  clearing_ff, clearing_in;
   logic [INDEX_BITS-1:0] clr_idx_ff, clr_idx_in;

   // Sweep every entry to tag zero, state invalid
   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == {INDEX_BITS{1'b1}}) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // Write port: sweep first, then the controller
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // Read port: pass the same-cycle write through to keep read-after-write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_idx == rd_idx)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_idx];
         end
      end
   end

   assign ready   = !clearing_ff;
   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/msc_snoop_logic.sv
// Coherence decision of the snoop controller: from one beat and the line's
// stored tag and state, form the result and the line's new tag and state.
// Depends on msc_pkg.
`default_nettype none

module msc_snoop_logic #(
   parameter int INDEX_BITS  = 6,
   parameter int OFFSET_BITS = 4,
   parameter int TAG_BITS    = 22
) (
   input  wire logic [2:0]              kind,
   input  wire logic [31:0]             address,
   input  wire logic                    own,
   input  wire logic                    is_store,
   input  wire logic [2:0]              set_state,
   input  wire logic [TAG_BITS-1:0]     cur_tag,
   input  wire logic [2:0]              cur_state,
   output msc_pkg::rsp_type             rsp,
   output logic [TAG_BITS-1:0]          new_tag,
   output logic [2:0]                   new_state
);

   import msc_pkg::*;

   logic [INDEX_BITS-1:0] idx;
   logic [TAG_BITS-1:0]   tag;
   logic [31:0]           victim_addr;
   logic [31:0]           aligned_addr;

   assign idx          = address[OFFSET_BITS +: INDEX_BITS];
   assign tag          = address[31 -: TAG_BITS];
   assign victim_addr  = {cur_tag, idx, {OFFSET_BITS{1'b0}}};
   assign aligned_addr = {address[31:OFFSET_BITS], {OFFSET_BITS{1'b0}}};

   always_comb begin
      rsp       = '0;
      new_tag   = cur_tag;
      new_state = cur_state;
      priority if (kind == KIND_REQUEST) begin
         // Front-end request: pick the bus command
         rsp.command_valid = 1'b1;
         if (cur_state == ST_SM) begin
            rsp.command = CMD_INV;
         end else if (is_store) begin
            rsp.command = CMD_RDX;
         end else begin
            rsp.command = CMD_RD;
         end
      end else if (kind == KIND_STATE_SET) begin
         new_state = set_state;
      end else if (kind == KIND_INV || kind == KIND_RD || kind == KIND_RDX) begin
         if (own) begin
            // Own broadcast: flush an M victim, refill on reads
            if (cur_state == ST_M) begin
               rsp.writeback_valid   = 1'b1;
               rsp.writeback_address = victim_addr;
            end
            if (kind != KIND_INV) begin
               rsp.fill_valid = 1'b1;
               new_tag        = tag;
            end
         end else if (cur_state == ST_I || cur_tag != tag) begin
            rsp.ignored = 1'b1;
         end else if (kind == KIND_INV) begin
            if (cur_state == ST_SM) begin
               new_state        = ST_IM;
               rsp.lost_upgrade = 1'b1;
            end else begin
               new_state = ST_I;
            end
         end else if (kind == KIND_RD) begin
            if (cur_state == ST_M) begin
               new_state             = ST_S;
               rsp.writeback_valid   = 1'b1;
               rsp.writeback_address = aligned_addr;
            end
         end else begin
            if (cur_state == ST_M) begin
               new_state             = ST_I;
               rsp.writeback_valid   = 1'b1;
               rsp.writeback_address = aligned_addr;
            end else if (cur_state == ST_S) begin
               new_state = ST_I;
            end else if (cur_state == ST_SM) begin
               new_state        = ST_IM;
               rsp.lost_upgrade = 1'b1;
            end
         end
      end else begin
         // Unused kinds: report the state only
      end
      rsp.line_state_after = new_state;
   end

endmodule

`default_nettype wire

// File: rtl/msi_snoop_coherence_controller.sv
// Top level of the MSI snoop controller: handshakes, the decision stage and
// the output register. Depends on msc_pkg, msc_line_store, msc_snoop_logic.
`default_nettype none

// Per-cache MSI snoop controller of a direct-mapped cache. Each request beat
// (front-end request, front-end state set, or own/foreign INV, BUS_RD,
// BUS_RDX broadcast) yields exactly one response beat. Tag and state of every
// line sit in one synchronous memory: a beat reads its line on acceptance;
// from the registered read the decision is made, and once the output side
// can take the result, the line is written back and the response registered.
// A beat to the same line taken in the cycle of that write sees it through a
// bypass; a new beat is taken every cycle while the response side keeps up.
// After reset the memory is swept clear, one line per cycle, and req_tready
// stays low until the sweep ends.
module msi_snoop_coherence_controller #(
   parameter int INDEX_BITS  = 6,
   parameter int OFFSET_BITS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata, low bit up: address[31:0], own, is_store, set_state[2:0], zero pad
   input  wire logic [msc_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // tuser: kind[2:0]
   input  wire logic [2:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata, low bit up: command_valid, command[1:0], writeback_valid,
   // writeback_address[31:0], fill_valid, ignored, lost_upgrade,
   // line_state_after[2:0], zero pad
   output logic [msc_pkg::RSP_DATA_BITS-1:0]        rsp_tdata
);

   import msc_pkg::*;

   localparam int TAG_BITS   = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
   localparam int ENTRY_BITS = TAG_BITS + 3;

   logic                  store_ready;
   logic                  accept;
   logic                  finishing;
   logic                  busy_ff, busy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [2:0]            kind_ff;
   logic [31:0]           addr_ff;
   logic                  own_ff, store_ff;
   logic [2:0]            set_ff;
   logic [ENTRY_BITS-1:0] entry_rd, entry_wr;
   logic [TAG_BITS-1:0]   new_tag;
   logic [2:0]            new_state;

   // Advance when the decision stage can hand its result to the output register
   assign finishing  = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = store_ready && (!busy_ff || finishing);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      busy_in      = accept ? 1'b1 : (finishing ? 1'b0 : busy_ff);
      rsp_valid_in = finishing ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the accepted beat and the result
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_tuser;
         addr_ff  <= req_tdata[31:0];
         own_ff   <= req_tdata[32];
         store_ff <= req_tdata[33];
         set_ff   <= req_tdata[36:34];
      end
      if (finishing) begin
         rsp_ff <= rsp_in;
      end
   end

   assign entry_wr = {new_tag, new_state};

   msc_line_store #(
      .INDEX_BITS (INDEX_BITS),
      .DATA_BITS  (ENTRY_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ready   (store_ready),
      .rd_en   (accept),
      .rd_idx  (req_tdata[OFFSET_BITS +: INDEX_BITS]),
      .rd_data (entry_rd),
      .wr_en   (finishing),
      .wr_idx  (addr_ff[OFFSET_BITS +: INDEX_BITS]),
      .wr_data (entry_wr)
   );

   msc_snoop_logic #(
      .INDEX_BITS  (INDEX_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .TAG_BITS    (TAG_BITS)
   ) u_logic (
      .kind      (kind_ff),
      .address   (addr_ff),
      .own       (own_ff),
      .is_store  (store_ff),
      .set_state (set_ff),
      .cur_tag   (entry_rd[ENTRY_BITS-1:3]),
      .cur_state (entry_rd[2:0]),
      .rsp       (rsp_in),
      .new_tag   (new_tag),
      .new_state (new_state)
   );

   // Pack the response beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.line_state_after, rsp_ff.lost_upgrade,
                        rsp_ff.ignored, rsp_ff.fill_valid, rsp_ff.writeback_address,
                        rsp_ff.writeback_valid, rsp_ff.command, rsp_ff.command_valid};

endmodule

`default_nettype wire

// File: bench/msc_checker.sv
// Checker for the MSI snoop controller: watches both stream channels, predicts
// each response from a private copy of the line tags and states, and compares.
// Depends on msc_pkg.
`default_nettype none

module msc_checker #(
   parameter int INDEX_BITS  = 6,
   parameter int OFFSET_BITS = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   // tdata, low bit up: address[31:0], own, is_store, set_state[2:0], zero pad
   input  wire logic [msc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // tuser: kind[2:0]
   input  wire logic [2:0]                        req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata, low bit up: command_valid, command[1:0], writeback_valid,
   // writeback_address[31:0], fill_valid, ignored, lost_upgrade,
   // line_state_after[2:0], zero pad
   input  wire logic [msc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output int                                     fail_count,
   output int                                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import msc_pkg::*;

   localparam int LINES    = 1 << INDEX_BITS;
   localparam int TAG_BITS = ADDR_BITS - INDEX_BITS - OFFSET_BITS;

   logic [TAG_BITS-1:0] line_tags [LINES];
   logic [2:0]          line_states [LINES];
   rsp_type             expected_rsp_q [$];

   // Work out the response of one request beat and update the line copy
   function automatic rsp_type snoop_response(input logic [2:0] kind,
                                              input logic [ADDR_BITS-1:0] addr,
                                              input logic own,
                                              input logic store,
                                              input logic [2:0] new_state);
      rsp_type                r;
      logic [INDEX_BITS-1:0]  idx;
      logic [TAG_BITS-1:0]    tag;
      logic [2:0]             st;
      logic [ADDR_BITS-1:0]   aligned;
      r       = '0;
      idx     = addr[OFFSET_BITS +: INDEX_BITS];
      tag     = addr[ADDR_BITS-1 -: TAG_BITS];
      st      = line_states[idx];
      aligned = {addr[ADDR_BITS-1:OFFSET_BITS], {OFFSET_BITS{1'b0}}};
      case (kind)
         KIND_REQUEST: begin
            r.command_valid = 1'b1;
            if (st == ST_SM) r.command = CMD_INV;
            else if (store)  r.command = CMD_RDX;
            else             r.command = CMD_RD;
         end
         KIND_STATE_SET: begin
            line_states[idx] = new_state;
         end
         KIND_INV, KIND_RD, KIND_RDX: begin
            if (own) begin
               // own broadcast: evict a dirty victim, then refill on reads
               if (st == ST_M) begin
                  r.writeback_valid   = 1'b1;
                  r.writeback_address = {line_tags[idx], idx, {OFFSET_BITS{1'b0}}};
               end
               if (kind != KIND_INV) begin
                  r.fill_valid   = 1'b1;
                  line_tags[idx] = tag;
               end
            end else if (st == ST_I || line_tags[idx] != tag) begin
               r.ignored = 1'b1;
            end else if (kind == KIND_INV) begin
               if (st == ST_SM) begin
                  line_states[idx] = ST_IM;
                  r.lost_upgrade   = 1'b1;
               end else begin
                  line_states[idx] = ST_I;
               end
            end else if (kind == KIND_RD) begin
               if (st == ST_M) begin
                  line_states[idx]    = ST_S;
                  r.writeback_valid   = 1'b1;
                  r.writeback_address = aligned;
               end
            end else begin
               if (st == ST_M) begin
                  line_states[idx]    = ST_I;
                  r.writeback_valid   = 1'b1;
                  r.writeback_address = aligned;
               end else if (st == ST_S) begin
                  line_states[idx] = ST_I;
               end else if (st == ST_SM) begin
                  line_states[idx] = ST_IM;
                  r.lost_upgrade   = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.line_state_after = line_states[idx];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Compare response beats first, then record the expectation of a new beat
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         fail_count = 0;
         expected_rsp_q.delete();
         for (int i = 0; i < LINES; i++) begin
            line_tags[i]   = '0;
            line_states[i] = ST_I;
         end
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (expected_rsp_q.size() == 0) begin
               $error("response beat with no expectation waiting");
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("command_valid", 32'(want.command_valid),
                           32'(got.command_valid));
               check_field("command", 32'(want.command), 32'(got.command));
               check_field("writeback_valid", 32'(want.writeback_valid),
                           32'(got.writeback_valid));
               check_field("writeback_address", want.writeback_address,
                           got.writeback_address);
               check_field("fill_valid", 32'(want.fill_valid), 32'(got.fill_valid));
               check_field("ignored", 32'(want.ignored), 32'(got.ignored));
               check_field("lost_upgrade", 32'(want.lost_upgrade),
                           32'(got.lost_upgrade));
               check_field("line_state_after", 32'(want.line_state_after),
                           32'(got.line_state_after));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_rsp_q.push_back(snoop_response(req_tuser, req_tdata[31:0],
                                                    req_tdata[32], req_tdata[33],
                                                    req_tdata[36:34]));
         end
      end
      pending <= expected_rsp_q.size();
   end

endmodule

`default_nettype wire

// File: bench/tb_msi_snoop_coherence_controller.sv
// Top of the MSI snoop controller bench: clock, reset, request stimulus in
// directed and randomized phases, response back-pressure and the verdict.
// Depends on msc_pkg, msc_checker and the controller RTL.
`default_nettype none

module tb_msi_snoop_coherence_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import msc_pkg::*;

   localparam int IDX_W = 6;
   localparam int OFF_W = 4;
   localparam int TAG_W = ADDR_BITS - IDX_W - OFF_W;
   localparam int PHASE_BEATS = 335;

   // Kind and state codes the block has no meaning for
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
   localparam logic [2:0] ST_SPARE_FIRST   = 3'd5;
   localparam logic [2:0] ST_SPARE_LAST    = 3'd7;

   localparam logic [ADDR_BITS-1:0] ADDR_TOP  = 32'hFFFF_FFFF;
   localparam logic [ADDR_BITS-1:0] ADDR_LOW  = 32'h0000_0050;
   localparam logic [ADDR_BITS-1:0] ADDR_ZERO = 32'h0000_0000;
   localparam logic [ADDR_BITS-1:0] ADDR_ALT  = 32'h0000_03F0;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [2:0]               req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int fail_count;
   int pending;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_off_cycles = 0;
   int beats_sent      = 0;

   msi_snoop_coherence_controller #(
      .INDEX_BITS  (IDX_W),
      .OFFSET_BITS (OFF_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   msc_checker #(
      .INDEX_BITS  (IDX_W),
      .OFFSET_BITS (OFF_W)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("FAIL msi_snoop_coherence_controller");
      $finish;
   end

   // Response side: random stalls, or a long hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offer one beat after a random gap; return at the edge that takes it
   task automatic send_beat(input logic [2:0] kind, input logic [ADDR_BITS-1:0] addr,
                            input logic own, input logic store,
                            input logic [2:0] new_state);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, new_state, store, own, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // Addresses cluster on a few lines and tags so snoops hit often
   function automatic logic [ADDR_BITS-1:0] pick_address();
      logic [TAG_W-1:0] tag;
      logic [IDX_W-1:0] idx;
      case ($urandom_range(3))
         0:       tag = '0;
         1:       tag = '1;
         2:       tag = TAG_W'($urandom_range(3));
         default: tag = TAG_W'($urandom);
      endcase
      idx = $urandom_range(1) ? IDX_W'($urandom_range(7)) : IDX_W'($urandom);
      return {tag, idx, OFF_W'($urandom)};
   endfunction

   function automatic logic [2:0] pick_state();
      case ($urandom_range(11))
         0:       return ST_I;
         1, 2:    return ST_S;
         3, 4, 5: return ST_M;
         6, 7, 8: return ST_SM;
         9, 10:   return ST_IM;
         default: return 3'($urandom_range(ST_SPARE_LAST, ST_SPARE_FIRST));
      endcase
   endfunction

   // Fully random beat, mostly of the defined kinds
   task automatic send_noise();
      logic [2:0] kind;
      if ($urandom_range(49) == 0) kind = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
      else                         kind = 3'($urandom_range(KIND_STATE_SET));
      send_beat(kind, $urandom_range(3) ? pick_address() : 32'($urandom),
                1'($urandom), 1'($urandom), 3'($urandom));
   endtask

   // Maybe fill a line, set its state, then hit it with snoops and requests
   task automatic send_episode();
      logic [ADDR_BITS-1:0] addr;
      logic [ADDR_BITS-1:0] target;
      logic [2:0]           kind;
      int                   n;
      addr = pick_address();
      if ($urandom_range(1)) begin
         send_beat($urandom_range(1) ? KIND_RD : KIND_RDX, addr, 1'b1, 1'($urandom),
                   3'($urandom));
      end
      send_beat(KIND_STATE_SET, addr, 1'($urandom), 1'($urandom), pick_state());
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) begin
         target = addr;
         if ($urandom_range(4) == 0) target[ADDR_BITS-1 -: TAG_W] = TAG_W'($urandom);
         target[OFF_W-1:0] = OFF_W'($urandom);
         case ($urandom_range(5))
            0:       kind = KIND_REQUEST;
            1:       kind = KIND_INV;
            2, 3:    kind = KIND_RD;
            default: kind = KIND_RDX;
         endcase
         send_beat(kind, target, ($urandom_range(5) == 0), 1'($urandom), 3'($urandom));
      end
   endtask

   // Main stimulus and verdict
   initial begin
      int target_count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: commands, own and foreign transitions, odd codes, field extremes
      send_beat(KIND_REQUEST, ADDR_ZERO, 1'b0, 1'b0, ST_I);
      send_beat(KIND_REQUEST, ADDR_TOP, 1'b1, 1'b1, ST_SPARE_LAST);
      send_beat(KIND_STATE_SET, ADDR_LOW, 1'b0, 1'b0, ST_SM);
      send_beat(KIND_REQUEST, ADDR_LOW, 1'b0, 1'b1, ST_I);
      send_beat(KIND_INV, ADDR_LOW, 1'b0, 1'b0, ST_I);
      send_beat(KIND_STATE_SET, ADDR_TOP, 1'b0, 1'b0, ST_M);
      send_beat(KIND_RD, ADDR_TOP, 1'b1, 1'b0, ST_I);
      send_beat(KIND_RD, ADDR_TOP, 1'b0, 1'b0, ST_I);
      send_beat(KIND_RDX, ADDR_TOP, 1'b0, 1'b0, ST_I);
      send_beat(KIND_STATE_SET, ADDR_TOP, 1'b0, 1'b0, ST_M);
      send_beat(KIND_RDX, ADDR_TOP, 1'b0, 1'b1, ST_I);
      send_beat(KIND_STATE_SET, ADDR_TOP, 1'b0, 1'b0, ST_SM);
      send_beat(KIND_RDX, ADDR_TOP, 1'b0, 1'b0, ST_I);
      send_beat(KIND_STATE_SET, ADDR_TOP, 1'b0, 1'b0, ST_M);
      send_beat(KIND_INV, ADDR_TOP, 1'b1, 1'b0, ST_I);
      send_beat(KIND_RD, ADDR_ALT, 1'b0, 1'b0, ST_I);
      send_beat(KIND_INV, ADDR_ZERO, 1'b0, 1'b0, ST_I);
      send_beat(KIND_STATE_SET, ADDR_ZERO, 1'b0, 1'b0, ST_SPARE_LAST);
      send_beat(KIND_INV, ADDR_ZERO, 1'b0, 1'b0, ST_I);
      send_beat(KIND_STATE_SET, ADDR_ZERO, 1'b0, 1'b0, ST_SPARE_FIRST);
      send_beat(KIND_RDX, ADDR_ZERO, 1'b0, 1'b0, ST_I);
      send_beat(KIND_RDX, ADDR_ZERO, 1'b1, 1'b0, ST_I);
      send_beat(KIND_SPARE_FIRST, ADDR_TOP, 1'b1, 1'b1, ST_SPARE_LAST);
      send_beat(KIND_SPARE_LAST, ADDR_TOP, 1'b1, 1'b1, ST_SPARE_LAST);

      // Random phases: no idling, sender gaps, receiver stalls, both, hold-off
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
            3:       begin send_idle_pct = 16; recv_stall_pct = 16; end
            default: begin
               send_idle_pct   = 0;
               recv_stall_pct  = 0;
               hold_off_cycles = 300;
            end
         endcase
         target_count = beats_sent + PHASE_BEATS;
         while (beats_sent < target_count) begin
            if ($urandom_range(9) < 7) send_episode();
            else                       send_noise();
         end
      end
      req_tvalid     <= 1'b0;
      recv_stall_pct  = 0;

      // Drain and let any stray beat show up
      do @(posedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS msi_snoop_coherence_controller");
      end else begin
         $display("FAIL msi_snoop_coherence_controller");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/msc_pkg.sv
rtl/msc_line_store.sv
rtl/msc_snoop_logic.sv
rtl/msi_snoop_coherence_controller.sv
bench/msc_checker.sv
bench/tb_msi_snoop_coherence_controller.sv
